FILE: rtl/gtcl_pkg.sv
// Shared sizes, field types and operation codes of the glyph tag cache.
`timescale 1ns / 1ps
package gtcl_pkg;

  localparam int ENTRIES     = 64;
  localparam int ATLAS_CELLS = 256;

  localparam int CpW   = 21;
  localparam int CellW = 9;
  localparam int AgeW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW  = $clog2(ENTRIES + 1);

  typedef logic [CpW-1:0]          cp_t;
  typedef logic signed [CellW-1:0] cell_t;
  typedef logic [AgeW-1:0]         age_t;
  typedef logic [CntW-1:0]         cnt_t;
  typedef logic [ENTRIES-1:0]      vec_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam cell_t CELL_NONE = '1;  // -1: glyph has no bitmap

endpackage

FILE: rtl/glyph_tag_cache_lru_unit.sv
// Glyph tag cache: fully associative codepoint store with LRU replacement.
//
// Input channel (in_valid_i / in_stall_o) carries one request beat: a lookup
// of codepoint_i, or a clear of all entries. On a lookup miss the remaining
// fields carry the outcome of glyph generation (found, outline, first and
// retry atlas cells); on a hit they are ignored.
// Output channel (out_valid_o / out_stall_i) returns one result beat per
// request, in order: hit, available, cell_res, and the codepoint of an entry
// evicted during that request.
// A beat accepted into the input register passes to the result register when
// the output is not stalled.
// One request per cycle is sustained while the output is not stalled: the tag
// compare over all entries, the oldest-entry match and the age update settle
// combinationally between the input register and the result register.
// The oldest entry is found by matching age against fill count minus one,
// since the ages of valid entries always form 0..count-1.
// Reset empties the store and drops any beats in flight. While the output is
// stalled the result register holds; one more request may wait in the input
// register, after which in_stall_o rises.
`timescale 1ns / 1ps
module glyph_tag_cache_lru_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            operation_i,
  input  gtcl_pkg::cp_t   codepoint_i,
  input  logic            glyph_found_i,
  input  logic            has_outline_i,
  input  gtcl_pkg::cell_t first_cell_i,
  input  gtcl_pkg::cell_t retry_cell_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            hit_o,
  output logic            available_o,
  output gtcl_pkg::cell_t cell_res_o,
  output logic            evicted_o,
  output gtcl_pkg::cp_t   evicted_codepoint_o
);
  import gtcl_pkg::*;

  localparam int  LimW     = CellW - 1;
  localparam bit  CellAll  = ATLAS_CELLS >= (2 ** LimW);
  localparam logic [LimW-1:0] CellLimit = LimW'(ATLAS_CELLS);
  localparam cnt_t CntFull = CntW'(ENTRIES);

  function automatic logic cell_usable(cell_t c);
    return !c[CellW-1] && (CellAll || (c[LimW-1:0] < CellLimit));
  endfunction

  // input register
  logic  in_vld_q;
  logic  op_q, found_q, outline_q;
  cp_t   cp_q;
  cell_t first_q, retry_q;

  // result register
  logic  out_vld_q;
  logic  hit_q, avail_q, ev_q;
  cell_t cell_q;
  cp_t   ev_cp_q;

  // tag store
  vec_t  valid_q, valid_d;
  cnt_t  count_q, count_d;
  cp_t   ent_cp_q   [ENTRIES];
  cell_t ent_cell_q [ENTRIES];
  age_t  ent_age_q  [ENTRIES];
  age_t  ent_age_d  [ENTRIES];

  logic  advance, in_take;
  logic  is_clear, hit, miss_found, first_ok, retry_ok;
  logic  ev_early, ev_full, evict, ins;
  vec_t  hit_vec, old_vec, free_vec, free_low, slot_vec;
  age_t  hit_age, old_age;
  cell_t hit_cell, ins_cell, res_cell;
  cp_t   old_cp;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign old_age = AgeW'(count_q - cnt_t'(1));

  always_comb begin
    hit_age  = '0;
    hit_cell = '0;
    old_cp   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (ent_cp_q[i] == cp_q);
      old_vec[i] = valid_q[i] && (ent_age_q[i] == old_age);
      hit_age    = hit_age  | (ent_age_q[i]  & {AgeW{hit_vec[i]}});
      hit_cell   = hit_cell | (ent_cell_q[i] & {CellW{hit_vec[i]}});
      old_cp     = old_cp   | (ent_cp_q[i]   & {CpW{old_vec[i]}});
    end
  end

  assign free_vec = ~valid_q;
  assign free_low = free_vec & (~free_vec + vec_t'(1));  // lowest free slot

  assign is_clear   = (op_q == OP_CLEAR);
  assign hit        = !is_clear && (|hit_vec);
  assign miss_found = !is_clear && !(|hit_vec) && found_q;
  assign first_ok   = cell_usable(first_q);
  assign retry_ok   = cell_usable(retry_q);
  // first placement failed: drop the oldest entry before the retry
  assign ev_early   = miss_found && outline_q && !first_ok && (count_q != '0);
  assign ins        = miss_found && (!outline_q || first_ok || retry_ok);
  assign ev_full    = ins && !ev_early && (count_q == CntFull);
  assign evict      = ev_early || ev_full;
  assign slot_vec   = evict ? old_vec : free_low;
  assign ins_cell   = !outline_q ? CELL_NONE : (first_ok ? first_q : retry_q);

  always_comb begin
    if (hit)      res_cell = hit_cell;
    else if (ins) res_cell = ins_cell;
    else          res_cell = '0;
  end

  always_comb begin
    valid_d   = valid_q;
    count_d   = count_q;
    ent_age_d = ent_age_q;
    if (is_clear) begin
      valid_d = '0;
      count_d = '0;
    end else if (hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_vec[i]) begin
          ent_age_d[i] = '0;
        end else if (valid_q[i] && (ent_age_q[i] < hit_age)) begin
          ent_age_d[i] = ent_age_q[i] + age_t'(1);
        end
      end
    end else begin
      count_d = count_q - cnt_t'(evict) + cnt_t'(ins);
      for (int i = 0; i < ENTRIES; i++) begin
        if (evict && old_vec[i]) begin
          valid_d[i] = 1'b0;
        end
        if (ins) begin
          if (slot_vec[i]) begin
            valid_d[i]   = 1'b1;
            ent_age_d[i] = '0;
          end else if (valid_q[i]) begin
            ent_age_d[i] = ent_age_q[i] + age_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
      count_q   <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        valid_q   <= valid_d;
        count_q   <= count_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q      <= operation_i;
      cp_q      <= codepoint_i;
      found_q   <= glyph_found_i;
      outline_q <= has_outline_i;
      first_q   <= first_cell_i;
      retry_q   <= retry_cell_i;
    end
    if (advance) begin
      hit_q   <= hit;
      avail_q <= hit || ins;
      cell_q  <= res_cell;
      ev_q    <= evict;
      ev_cp_q <= evict ? old_cp : '0;
      for (int i = 0; i < ENTRIES; i++) begin
        ent_age_q[i] <= ent_age_d[i];
        if (ins && slot_vec[i]) begin
          ent_cp_q[i]   <= cp_q;
          ent_cell_q[i] <= ins_cell;
        end
      end
    end
  end

  assign out_valid_o         = out_vld_q;
  assign hit_o               = hit_q;
  assign available_o         = avail_q;
  assign cell_res_o          = cell_q;
  assign evicted_o           = ev_q;
  assign evicted_codepoint_o = ev_cp_q;

  // fill count tracks the valid bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("fill count out of step with valid bits");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("fill count above capacity");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_clear |=> valid_q == '0)
    else $error("clear left valid entries");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && hit_q |-> avail_q && !ev_q)
    else $error("hit result with eviction or without glyph");

  a_single_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !is_clear |-> $onehot0(hit_vec))
    else $error("codepoint held in more than one entry");

endmodule

FILE: tb/sv/glyph_tag_cache_lru_unit_tb.sv
// Self-checking testbench of the glyph tag cache with a built-in LRU predictor.
`timescale 1ns / 1ps
module glyph_tag_cache_lru_unit_tb;
  import gtcl_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_BEATS = 1100;
  localparam int CP_MAX = 1114111;

  typedef struct packed {
    logic  drain;  // not a beat: sender waits here until all results are back
    logic  op;
    cp_t   cp;
    logic  found;
    logic  outline;
    cell_t first;
    cell_t retry;
  } glyph_req_t;

  typedef struct packed {
    logic  hit;
    logic  avail;
    cell_t cell_val;
    logic  ev;
    cp_t   ev_cp;
  } glyph_res_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  logic  operation_i = OP_LOOKUP;
  cp_t   codepoint_i = '0;
  logic  glyph_found_i = 1'b0;
  logic  has_outline_i = 1'b0;
  cell_t first_cell_i = '0;
  cell_t retry_cell_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  logic  hit_o;
  logic  available_o;
  cell_t cell_res_o;
  logic  evicted_o;
  cp_t   evicted_codepoint_o;

  glyph_tag_cache_lru_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .codepoint_i        (codepoint_i),
    .glyph_found_i      (glyph_found_i),
    .has_outline_i      (has_outline_i),
    .first_cell_i       (first_cell_i),
    .retry_cell_i       (retry_cell_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .hit_o              (hit_o),
    .available_o        (available_o),
    .cell_res_o         (cell_res_o),
    .evicted_o          (evicted_o),
    .evicted_codepoint_o(evicted_codepoint_o)
  );

  always #4 clk_i = ~clk_i;

  // shadow copy of the tag store
  bit    tag_valid [ENTRIES];
  cp_t   tag_cp    [ENTRIES];
  cell_t tag_cell  [ENTRIES];
  int    tag_age   [ENTRIES];

  glyph_req_t  pending_q[$];
  glyph_res_t  result_q[$];
  cp_t         cp_pool[100];
  logic        go = 1'b0;
  logic        in_taken = 1'b0;
  int          errors = 0;
  int          beats_in = 0;
  int          idle_cycles = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  int          hold_left = 0;
  int          holds_done = 0;
  int          hold_at = 250;
  int          mode_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  function automatic bit cell_usable(cell_t c);
    return c >= 0 && int'(c) < ATLAS_CELLS;
  endfunction

  function automatic int oldest_slot();
    int best;
    best = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && (best < 0 || tag_age[i] > tag_age[best])) best = i;
    return best;
  endfunction

  // Applies one request to the shadow store and returns the result it should produce.
  function automatic glyph_res_t lru_access(glyph_req_t rq);
    glyph_res_t r;
    int         h;
    int         a;
    int         slot;
    bit         ok;
    cell_t      c;
    r = '0;
    h = -1;
    if (rq.op == OP_CLEAR) begin
      foreach (tag_valid[i]) tag_valid[i] = 1'b0;
      return r;
    end
    for (int i = 0; i < ENTRIES; i++)
      if (tag_valid[i] && tag_cp[i] == rq.cp) h = i;
    if (h >= 0) begin
      a = tag_age[h];
      for (int i = 0; i < ENTRIES; i++)
        if (tag_valid[i] && tag_age[i] < a) tag_age[i]++;
      tag_age[h] = 0;
      r.hit = 1'b1;
      r.avail = 1'b1;
      r.cell_val = tag_cell[h];
    end else if (rq.found) begin
      ok = 1'b1;
      c = CELL_NONE;
      if (rq.outline) begin
        if (cell_usable(rq.first)) begin
          c = rq.first;
        end else begin
          slot = oldest_slot();
          if (slot >= 0) begin
            tag_valid[slot] = 1'b0;
            r.ev = 1'b1;
            r.ev_cp = tag_cp[slot];
          end
          if (cell_usable(rq.retry)) c = rq.retry;
          else ok = 1'b0;
        end
      end
      if (ok) begin
        slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
          if (!tag_valid[i]) slot = i;
        if (slot < 0) begin
          // full store: the oldest entry gives up its slot
          slot = oldest_slot();
          r.ev = 1'b1;
          r.ev_cp = tag_cp[slot];
          tag_valid[slot] = 1'b0;
        end
        for (int i = 0; i < ENTRIES; i++)
          if (tag_valid[i]) tag_age[i]++;
        tag_valid[slot] = 1'b1;
        tag_cp[slot] = rq.cp;
        tag_cell[slot] = c;
        tag_age[slot] = 0;
        r.avail = 1'b1;
        r.cell_val = c;
      end
    end
    return r;
  endfunction

  function automatic cell_t rand_cell(int pct_usable);
    if ($urandom_range(0, 99) < pct_usable) return cell_t'($urandom_range(0, 255));
    return CELL_NONE;
  endfunction

  function automatic void push_req(logic op, cp_t cp, logic found, logic outline,
                                   cell_t first, cell_t retry);
    glyph_req_t rq;
    rq = '{drain: 1'b0, op: op, cp: cp, found: found, outline: outline,
           first: first, retry: retry};
    pending_q.push_back(rq);
  endfunction

  function automatic void push_drain();
    glyph_req_t rq;
    rq = '0;
    rq.drain = 1'b1;
    pending_q.push_back(rq);
  endfunction

  // sender: bursts of beats with random gaps; payload held while stalled
  always @(negedge clk_i) begin
    if (!go) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // beat still waiting
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left--;
    end else if (pending_q.size() > 0 && pending_q[0].drain) begin
      in_valid_i <= 1'b0;
      if (result_q.size() == 0) void'(pending_q.pop_front());
    end else if (pending_q.size() > 0) begin
      operation_i   <= pending_q[0].op;
      codepoint_i   <= pending_q[0].cp;
      glyph_found_i <= pending_q[0].found;
      has_outline_i <= pending_q[0].outline;
      first_cell_i  <= pending_q[0].first;
      retry_cell_i  <= pending_q[0].retry;
      in_valid_i    <= 1'b1;
      void'(pending_q.pop_front());
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 50);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: changing stall patterns plus two long hold-offs
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (holds_done < 2 && beats_in >= hold_at) begin
      out_stall_i <= 1'b1;
      hold_left = HOLD_CYCLES;
      holds_done++;
      hold_at = 750;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= !out_stall_i;
      endcase
    end
  end

  // accepted beats feed the predictor; results are checked in order
  always @(posedge clk_i) begin
    glyph_req_t seen;
    glyph_res_t got;
    glyph_res_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        got = '{hit: hit_o, avail: available_o, cell_val: cell_res_o, ev: evicted_o,
                ev_cp: evicted_codepoint_o};
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat with nothing expected: hit=%0b avail=%0b cell=%0d",
                     $realtime, got.hit, got.avail, got.cell_val);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $write("%0t: mismatch exp hit=%0b avail=%0b cell=%0d ev=%0b ev_cp=%h",
                     $realtime, want.hit, want.avail, want.cell_val, want.ev, want.ev_cp);
              $display(" | got hit=%0b avail=%0b cell=%0d ev=%0b ev_cp=%h",
                       got.hit, got.avail, got.cell_val, got.ev, got.ev_cp);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        seen = '{drain: 1'b0, op: operation_i, cp: codepoint_i, found: glyph_found_i,
                 outline: has_outline_i, first: first_cell_i, retry: retry_cell_i};
        result_q.push_back(lru_access(seen));
        beats_in++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (go) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    foreach (tag_valid[i]) tag_valid[i] = 1'b0;
    foreach (cp_pool[i]) cp_pool[i] = (i < 8) ? cp_t'(i * 3) : cp_t'($urandom_range(0, CP_MAX));

    // directed: insert kinds, hits, atlas-full retry paths, clears on occupied and empty store
    push_req(OP_LOOKUP, 21'd0, 1'b1, 1'b1, 9'sd0, 9'sd5);
    push_req(OP_LOOKUP, 21'd0, 1'b0, 1'b0, CELL_NONE, CELL_NONE);
    push_req(OP_LOOKUP, 21'h10FFFF, 1'b1, 1'b0, 9'sd255, 9'sd255);
    push_req(OP_LOOKUP, 21'd5, 1'b0, 1'b1, 9'sd10, 9'sd10);
    push_req(OP_LOOKUP, 21'd6, 1'b1, 1'b1, 9'sd255, CELL_NONE);
    push_req(OP_LOOKUP, 21'h10FFFF, 1'b1, 1'b1, 9'sd7, 9'sd7);
    push_req(OP_LOOKUP, 21'd7, 1'b1, 1'b1, CELL_NONE, 9'sd17);
    push_req(OP_LOOKUP, 21'd8, 1'b1, 1'b1, CELL_NONE, CELL_NONE);
    push_req(OP_LOOKUP, 21'd6, 1'b1, 1'b1, 9'sd1, 9'sd1);
    push_req(OP_LOOKUP, 21'd7, 1'b0, 1'b0, 9'sd0, 9'sd0);
    push_req(OP_CLEAR, 21'h1FFFFF, 1'b1, 1'b1, CELL_NONE, CELL_NONE);
    push_req(OP_LOOKUP, 21'd7, 1'b0, 1'b1, 9'sd3, 9'sd3);
    push_req(OP_LOOKUP, 21'd9, 1'b1, 1'b1, CELL_NONE, 9'sd3);
    push_req(OP_LOOKUP, 21'd10, 1'b1, 1'b1, CELL_NONE, CELL_NONE);
    push_req(OP_LOOKUP, 21'd11, 1'b1, 1'b1, CELL_NONE, CELL_NONE);
    push_req(OP_LOOKUP, 21'd12, 1'b1, 1'b0, CELL_NONE, CELL_NONE);
    push_req(OP_LOOKUP, 21'd12, 1'b1, 1'b1, 9'sd200, 9'sd200);
    push_req(OP_CLEAR, 21'd0, 1'b0, 1'b0, 9'sd0, 9'sd0);
    push_req(OP_CLEAR, 21'd0, 1'b0, 1'b0, 9'sd0, 9'sd0);
    push_req(OP_LOOKUP, 21'd12, 1'b1, 1'b1, 9'sd128, 9'sd64);
    push_drain();

    // random: a small pool of hot codepoints keeps the store full and hitting
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      r = $urandom_range(0, 999);
      if (n == RANDOM_BEATS / 2) push_drain();
      if (r < 6)
        push_req(OP_CLEAR, cp_t'($urandom_range(0, CP_MAX)), 1'($urandom), 1'($urandom),
                 rand_cell(50), rand_cell(50));
      else
        push_req(OP_LOOKUP,
                 (r < 850) ? cp_pool[$urandom_range(0, 99)] : cp_t'($urandom_range(0, CP_MAX)),
                 $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0,
                 rand_cell(80), rand_cell(60));
    end

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    go <= 1'b1;

    while (pending_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (result_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
